>>> hw/rtl/plst_pkg.sv
// plst_pkg: sizes, codes and item types for the positional list store.
// Used by plst_cell and positional_list_store_core. No dependencies.
`default_nettype none

package plst_pkg;

  // List sizing
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 8;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  // Broadcast cell commands
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  position;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [31:0] removed_value;
    logic        removed_valid;
    logic [4:0]  entry_count;
    logic [31:0] first_value;
    logic [31:0] last_value;
  } out_item_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic [1:0]            op;
    logic [IDX_W-1:0]      at;
    logic [DATA_WIDTH-1:0] value;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic                  last_en;
    logic [IDX_W-1:0]      last_idx;
  } cell_ctrl_t;

  // Gated words a cell offers to the OR reductions
  typedef struct packed {
    logic [DATA_WIDTH-1:0] rd;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] last;
  } cell_tap_t;

endpackage

`default_nettype wire

>>> hw/rtl/plst_cell.sv
// plst_cell: one list slot; shifts with its neighbors on insert and remove.
// Depends on plst_pkg.
`default_nettype none

module plst_cell (
  input  wire                             clk,
  input  wire  [plst_pkg::IDX_W-1:0]      cell_idx,
  input  wire  plst_pkg::cell_ctrl_t      ctrl,
  input  wire  [plst_pkg::DATA_WIDTH-1:0] left_word,
  input  wire  [plst_pkg::DATA_WIDTH-1:0] right_word,
  output logic [plst_pkg::DATA_WIDTH-1:0] word_r,
  output plst_pkg::cell_tap_t             tap
);
  import plst_pkg::*;

  logic [DATA_WIDTH-1:0] word_nxt;

  // Next word: new value or left word on insert, right word on remove
  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (cell_idx == ctrl.at) begin
          word_nxt = ctrl.value;
        end else if (cell_idx > ctrl.at) begin
          word_nxt = left_word;
        end
      end
      CELL_REMOVE: begin
        if (cell_idx >= ctrl.at) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Taps for read, removed and last word
  always_comb begin
    tap.rd   = (ctrl.rd_en && cell_idx == ctrl.rd_idx) ? word_r : '0;
    tap.rem  = (ctrl.op == CELL_REMOVE && cell_idx == ctrl.at) ? word_r : '0;
    tap.last = (ctrl.last_en && cell_idx == ctrl.last_idx) ? word_r : '0;
  end

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_store_core.sv
// positional_list_store_core: ordered list of words in a row of shifting cells.
// Depends on plst_pkg and plst_cell.
// Result registered the cycle after accept; one item per cycle while in_ready.
// All cells shift in parallel on insert/remove.
// Reset: clears the entry count and the output valid; cell words are not reset.
`default_nettype none

module positional_list_store_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  plst_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output plst_pkg::out_item_t  out_data
);
  import plst_pkg::*;

  logic                  in_acc;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [31:0]           read_r, read_nxt;
  logic [31:0]           rem_r, rem_nxt;
  logic                  rem_ok_r, rem_ok_nxt;
  cell_ctrl_t            ctrl;
  logic [CMP_W-1:0]      pos_w, cnt_w;
  logic [DATA_WIDTH-1:0] words [CAPACITY];
  cell_tap_t             taps  [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_or, rem_or, last_or;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign pos_w = CMP_W'(in_data.position);
  assign cnt_w = CMP_W'(count_r);

  // Decode the request into a cell command and the result status
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.at       = '0;
    ctrl.value    = in_data.value[DATA_WIDTH-1:0];
    ctrl.rd_en    = 1'b0;
    ctrl.rd_idx   = in_data.position[IDX_W-1:0];
    ctrl.last_en  = (count_r != '0);
    ctrl.last_idx = IDX_W'(count_r - CNT_W'(1));
    status_nxt    = ST_OK;
    count_nxt     = count_r;
    unique case (in_data.mode)
      MODE_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op   = in_acc ? CELL_INSERT : CELL_HOLD;
          ctrl.at   = (pos_w >= cnt_w) ? IDX_W'(count_r) : in_data.position[IDX_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.op   = in_acc ? CELL_REMOVE : CELL_HOLD;
          ctrl.at   = (pos_w >= cnt_w - CMP_W'(1)) ? IDX_W'(count_r - CNT_W'(1))
                                                   : in_data.position[IDX_W-1:0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_nxt = ST_PAST_END;
        end else begin
          ctrl.rd_en = 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = words[g+1];
    end
    plst_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctrl       (ctrl),
      .left_word  (left_w),
      .right_word (right_w),
      .word_r     (words[g]),
      .tap        (taps[g])
    );
  end

  // OR the gated cell taps together
  always_comb begin
    rd_or   = '0;
    rem_or  = '0;
    last_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or   = rd_or   | taps[i].rd;
      rem_or  = rem_or  | taps[i].rem;
      last_or = last_or | taps[i].last;
    end
  end

  // Result register next values
  always_comb begin
    out_valid_nxt = out_valid_r;
    read_nxt      = read_r;
    rem_nxt       = rem_r;
    rem_ok_nxt    = rem_ok_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      read_nxt      = ctrl.rd_en ? 32'(rd_or) : 32'd0;
      rem_ok_nxt    = (ctrl.op == CELL_REMOVE);
      rem_nxt       = (ctrl.op == CELL_REMOVE) ? 32'(rem_or) : 32'd0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    read_r   <= read_nxt;
    rem_r    <= rem_nxt;
    rem_ok_r <= rem_ok_nxt;
    if (in_acc) begin
      status_r <= status_nxt;
    end
  end

  // Summary fields come straight from the cells, which hold while the item waits
  assign out_valid              = out_valid_r;
  assign out_data.status        = status_r;
  assign out_data.read_value    = read_r;
  assign out_data.removed_value = rem_r;
  assign out_data.removed_valid = rem_ok_r;
  assign out_data.entry_count   = 5'(count_r);
  assign out_data.first_value   = (count_r != '0) ? 32'(words[0]) : 32'd0;
  assign out_data.last_value    = 32'(last_or);

endmodule

`default_nettype wire
